[hw/rtl/packed_int4_u8_dot_product_macros.svh]
// Assertion macros shared by the checker of the int4 x u8 dot product block.
// No dependencies.
`ifndef PACKED_INT4_U8_DOT_PRODUCT_MACROS_SVH
`define PACKED_INT4_U8_DOT_PRODUCT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I4DP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i4dp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define I4DP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i4dp assertion failed");

// Implication checked during reset as well.
`define I4DP_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("i4dp assertion failed");

`endif

[hw/rtl/i4dp_pkg.sv]
// Shared types, widths and the per-item product function of the dot product block.
// No dependencies.
`default_nettype none

package i4dp_pkg;

    localparam int LANES     = 4;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int IN_W      = LANES * BYTE_W;
    localparam int ITEM_W    = 15;   // 8 products of 255 * 15 fit in 15 bits
    localparam int SUM_W     = 25;
    localparam int TDATA_IN  = 3 * IN_W;
    localparam int TDATA_OUT = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic              last;
        logic [ITEM_W-1:0] item_sum;
    } i4dp_entry_t;

    // Sum of the eight activation * weight-nibble products of one item.
    function automatic logic [ITEM_W-1:0] item_products(
        input logic [IN_W-1:0] wbytes,
        input logic [IN_W-1:0] act_lo,
        input logic [IN_W-1:0] act_hi
    );
        logic [ITEM_W-1:0] total;
        logic [BYTE_W-1:0] wb;
        total = '0;
        for (int i = 0; i < LANES; i++) begin
            wb = wbytes[i*BYTE_W +: BYTE_W];
            total = total
                  + ITEM_W'(act_lo[i*BYTE_W +: BYTE_W]) * ITEM_W'(wb[NIB_W-1:0])
                  + ITEM_W'(act_hi[i*BYTE_W +: BYTE_W]) * ITEM_W'(wb[BYTE_W-1:NIB_W]);
        end
        return total;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/i4dp_front.sv]
// Front stage: takes input transfers and registers the item's product sum.
// Depends on i4dp_pkg.
`default_nettype none

module i4dp_front
    import i4dp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    input  wire logic [TDATA_IN-1:0] s_axis_tdata,
    input  wire logic                s_axis_tlast,
    output      logic                q_valid,
    input  wire logic                q_ready,
    output      i4dp_entry_t         q_entry
);

    logic        valid_reg;
    i4dp_entry_t entry_reg;
    logic        take;

    assign s_axis_tready = !valid_reg || q_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = valid_reg;
    assign q_entry       = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg.last     <= s_axis_tlast;
            entry_reg.item_sum <= item_products(s_axis_tdata[IN_W-1:0],
                                                s_axis_tdata[2*IN_W-1:IN_W],
                                                s_axis_tdata[3*IN_W-1:2*IN_W]);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/i4dp_queue.sv]
// Short FIFO of item sums between the front and back stages.
// Depends on i4dp_pkg.
`default_nettype none

module i4dp_queue
    import i4dp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output      logic        push_ready,
    input  wire i4dp_entry_t push_entry,
    output      logic        pop_valid,
    input  wire logic        pop_ready,
    output      i4dp_entry_t pop_entry
);

    i4dp_entry_t        mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/i4dp_back.sv]
// Back stage: saturating accumulator and the result register.
// Depends on i4dp_pkg.
`default_nettype none

module i4dp_back
    import i4dp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output      logic                 q_ready,
    input  wire i4dp_entry_t          q_entry,
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output      logic [TDATA_OUT-1:0] m_axis_tdata
);

    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic [SUM_W:0]   raw_sum;
    logic             pop;
    logic             out_free;

    assign out_free = !out_valid_reg || m_axis_tready;
    // a run-closing entry waits for the result register, others always drain
    assign q_ready  = !q_entry.last || out_free;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        raw_sum  = {1'b0, acc_reg} + (SUM_W + 1)'(q_entry.item_sum);
        acc_next = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_reg <= q_entry.last ? '0 : acc_next;
            end
            if (pop && q_entry.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_entry.last)
        begin
            out_sum_reg <= acc_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(TDATA_OUT - SUM_W)'(0), out_sum_reg};

endmodule

`default_nettype wire

[hw/rtl/packed_int4_u8_dot_product.sv]
// Top level of the packed int4 weight x u8 activation dot product.
// The run's last item passes the front register, the queue and the result register.
// One item per cycle unless a last item waits; the accumulator feedback is one add.
// The 4-entry queue lets the input keep flowing while a result waits on the output.
// Reset (rst_n, async, active low) clears the running sum, queue and valid flags.
// Depends on i4dp_pkg, i4dp_front, i4dp_queue, i4dp_back.
`default_nettype none

module packed_int4_u8_dot_product
    import i4dp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // [31:0] weight_bytes, [63:32] act_first_half, [95:64] act_second_half
    input  wire logic [TDATA_IN-1:0]  s_axis_tdata,
    input  wire logic                 s_axis_tlast,   // last_of_dot
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [24:0] dot_sum, [31:25] zero
    output      logic [TDATA_OUT-1:0] m_axis_tdata
);

    logic        fq_valid;
    logic        fq_ready;
    i4dp_entry_t fq_entry;
    logic        qb_valid;
    logic        qb_ready;
    i4dp_entry_t qb_entry;

    i4dp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_entry       (fq_entry)
    );

    i4dp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_entry (fq_entry),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_entry  (qb_entry)
    );

    i4dp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_entry       (qb_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/i4dp_checker.sv]
// Port-level checks for the dot product block, bound to the top level.
// Depends on i4dp_pkg and packed_int4_u8_dot_product_macros.svh.
`default_nettype none
`include "packed_int4_u8_dot_product_macros.svh"

module i4dp_checker
    import i4dp_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [TDATA_OUT-1:0] m_axis_tdata
);

    // stalled result holds its value
    `I4DP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // bits above the 25-bit sum are padding
    `I4DP_ASSERT_NOW(a_out_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[TDATA_OUT-1:SUM_W] == '0)

    // no result shown while in reset
    `I4DP_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n, !m_axis_tvalid)

endmodule

bind packed_int4_u8_dot_product i4dp_checker u_i4dp_checker (.*);

`default_nettype wire
